/* design/ilb_pkg.sv */
package ilb_pkg;

    // List geometry
    localparam int CAPACITY = 32;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Action codes
    localparam logic [1:0] ACT_APPEND = 2'd0;
    localparam logic [1:0] ACT_INSERT = 2'd1;
    localparam logic [1:0] ACT_DELETE = 2'd2;
    localparam logic [1:0] ACT_READ   = 2'd3;

    // Status codes
    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_BADINDEX = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    typedef struct packed {
        logic [1:0]         action;
        logic [4:0]         index;
        logic signed [31:0] value;
    } t_in;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic [5:0]         entry_count;
        logic [1:0]         status;
    } t_out;

    // Per-beat command broadcast to every cell
    typedef struct packed {
        logic             do_load;
        logic             do_up;
        logic             do_down;
        logic [IDX_W-1:0] sel;
    } t_cell_ctl;

endpackage

/* design/ilb_cell.sv */
module ilb_cell (
    input  logic                       i_clk,
    input  logic [ilb_pkg::IDX_W-1:0]  i_pos,
    input  ilb_pkg::t_cell_ctl         i_ctl,
    input  logic [31:0]                i_value,
    input  logic [31:0]                i_left,
    input  logic [31:0]                i_right,
    output logic [31:0]                o_entry,
    output logic [31:0]                o_tap
);
    import ilb_pkg::*;

    logic [31:0] r_entry;
    logic [31:0] n_entry;

    // Load, take from the lower neighbor (insert) or upper neighbor (delete)
    always_comb begin
        n_entry = r_entry;
        if (i_ctl.do_load && (i_pos == i_ctl.sel)) begin
            n_entry = i_value;
        end else if (i_ctl.do_up && (i_pos > i_ctl.sel)) begin
            n_entry = i_left;
        end else if (i_ctl.do_down && (i_pos >= i_ctl.sel)) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    // Read tap: only the selected cell drives nonzero
    assign o_tap   = (i_pos == i_ctl.sel) ? r_entry : 32'd0;

endmodule

/* design/indexed_list_buffer_top.sv */
// Ordered list buffer: up to CAPACITY signed 32-bit entries plus a count.
// Input channel (i_in_valid / o_in_ready / i_in_data) carries one command
// beat: append, insert at index, delete at index, or read at index.
// Output channel (o_out_valid / i_out_ready / o_out_data) returns exactly
// one beat per command: read value (zero unless a good read), the entry
// count after the command, and a status (done, bad index, full).
// Latency: the result beat is valid on the cycle after the command is
// accepted. Throughput: one command per cycle while the receiver keeps up.
// The entries live in a row of cells, one per list position; every cell
// picks its next value from the command data or a neighbor in the same
// edge, so inserts and deletes shift the whole list at once.
// The result sits in an output register; a new command is taken while that
// register is empty or being drained this cycle. When the receiver stalls,
// the result holds and o_in_ready drops until it is taken.
// Reset (i_rst_n low, synchronous) empties the list and the output register.
// Entry contents are not cleared; only positions below the count are read.
module indexed_list_buffer_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  ilb_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output ilb_pkg::t_out o_out_data
);
    import ilb_pkg::*;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_out_valid;
    t_out             r_out;
    t_out             n_out;
    logic             in_fire;
    logic             idx_good;
    logic             full;
    t_cell_ctl        ctl;
    logic [31:0]      cell_entry [CAPACITY];
    logic [31:0]      cell_tap   [CAPACITY];
    logic [31:0]      rd_or;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_fire    = i_in_valid && o_in_ready;
    assign idx_good   = int'(i_in_data.index) < int'(r_count);
    assign full       = int'(r_count) >= CAPACITY;

    // Decode the command into the cell broadcast, next count and status
    always_comb begin
        ctl         = '0;
        n_count     = r_count;
        n_out       = '0;
        n_out.status = ST_DONE;
        ctl.sel     = IDX_W'(i_in_data.index);
        unique case (i_in_data.action)
            ACT_APPEND: begin
                ctl.sel = IDX_W'(r_count);
                if (full) begin
                    n_out.status = ST_FULL;
                end else begin
                    ctl.do_load = in_fire;
                    n_count     = r_count + CNT_W'(1);
                end
            end
            ACT_INSERT: begin
                if (!idx_good) begin
                    n_out.status = ST_BADINDEX;
                end else if (full) begin
                    n_out.status = ST_FULL;
                end else begin
                    ctl.do_load = in_fire;
                    ctl.do_up   = in_fire;
                    n_count     = r_count + CNT_W'(1);
                end
            end
            ACT_DELETE: begin
                if (!idx_good) begin
                    n_out.status = ST_BADINDEX;
                end else begin
                    ctl.do_down = in_fire;
                    n_count     = r_count - CNT_W'(1);
                end
            end
            ACT_READ: begin
                if (!idx_good) begin
                    n_out.status = ST_BADINDEX;
                end else begin
                    n_out.read_value = rd_or;
                end
            end
            default: begin
                n_out.status = ST_BADINDEX;
            end
        endcase
        n_out.entry_count = 6'(n_count);
    end

    // Row of cells, each wired to its neighbors
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [31:0] left_w;
        logic [31:0] right_w;
        if (g == 0) begin : g_first
            assign left_w = 32'd0;
        end else begin : g_mid_l
            assign left_w = cell_entry[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign right_w = 32'd0;
        end else begin : g_mid_r
            assign right_w = cell_entry[g+1];
        end
        ilb_cell u_cell (
            .i_clk   (i_clk),
            .i_pos   (IDX_W'(g)),
            .i_ctl   (ctl),
            .i_value (i_in_data.value),
            .i_left  (left_w),
            .i_right (right_w),
            .o_entry (cell_entry[g]),
            .o_tap   (cell_tap[g])
        );
    end

    // Combine the one-hot read taps
    always_comb begin
        rd_or = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            rd_or = rd_or | cell_tap[k];
        end
    end

    // Count and output beat registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

/* design/ilb_checker.sv */
module ilb_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_ready,
    input ilb_pkg::t_in  i_in_data,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input ilb_pkg::t_out o_out_data
);
    import ilb_pkg::*;

    // Stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result beat changed while stalled");

    // Every accepted command yields a result next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> o_out_valid)
        else $error("no result after accepted command");

    // An empty output register never blocks the input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output");

    // Full status only when the list is at capacity
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == ST_FULL
        |-> o_out_data.entry_count == 6'(CAPACITY))
        else $error("full status below capacity");

    // Failed commands return zero data
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != ST_DONE |-> o_out_data.read_value == 0)
        else $error("nonzero data on failed command");

endmodule

bind indexed_list_buffer_top ilb_checker u_ilb_checker (.*);

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
    import ilb_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 1440;

    // Shadow copy of the list; predicts one result beat per accepted command
    class list_scoreboard;
        logic signed [31:0] shadow [CAPACITY];
        int unsigned        count;
        t_out               expected_q [$];
        int                 error_count;

        function new();
            count       = 0;
            error_count = 0;
        endfunction

        function void note_command(t_in cmd);
            t_out        want;
            int unsigned i;
            want = '0;
            case (cmd.action)
                ACT_APPEND: begin
                    if (count >= CAPACITY) begin
                        want.status = ST_FULL;
                    end else begin
                        shadow[count] = cmd.value;
                        count++;
                    end
                end
                ACT_INSERT: begin
                    // bad index wins over full
                    if (cmd.index >= count) begin
                        want.status = ST_BADINDEX;
                    end else if (count >= CAPACITY) begin
                        want.status = ST_FULL;
                    end else begin
                        for (i = count; i > cmd.index; i--)
                            shadow[i] = shadow[i - 1];
                        shadow[cmd.index] = cmd.value;
                        count++;
                    end
                end
                ACT_DELETE: begin
                    if (cmd.index >= count) begin
                        want.status = ST_BADINDEX;
                    end else begin
                        for (i = cmd.index; i + 1 < count; i++)
                            shadow[i] = shadow[i + 1];
                        count--;
                    end
                end
                default: begin
                    if (cmd.index >= count)
                        want.status = ST_BADINDEX;
                    else
                        want.read_value = shadow[cmd.index];
                end
            endcase
            want.entry_count = 6'(count);
            expected_q = {expected_q, want};
        endfunction

        function void check_result(t_out got);
            t_out want;
            if (expected_q.size() == 0) begin
                $error("result beat with nothing pending: read_value=%0d %s%0d status=%0d",
                       got.read_value, "entry_count=", got.entry_count, got.status);
                error_count++;
                return;
            end
            want = expected_q.pop_front();
            if (got.read_value !== want.read_value) begin
                $error("read_value: expected %0d, got %0d", want.read_value, got.read_value);
                error_count++;
            end
            if (got.entry_count !== want.entry_count) begin
                $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
                error_count++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                error_count++;
            end
        endfunction
    endclass

    logic  i_clk;
    logic  i_rst_n;
    logic  i_in_valid;
    logic  o_in_ready;
    t_in   i_in_data;
    logic  o_out_valid;
    logic  i_out_ready;
    t_out  o_out_data;

    logic  steady;
    int    cycle_count;

    list_scoreboard sb;

    indexed_list_buffer_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Receiver back-pressure, off during the steady stretch
    always @(negedge i_clk) begin
        i_out_ready <= steady || ($urandom_range(0, 99) >= 17);
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(o_out_data);
    end

    function automatic t_in command_beat(logic [1:0] act, int unsigned idx, logic [31:0] val);
        t_in cmd;
        cmd.action = act;
        cmd.index  = 5'(idx);
        cmd.value  = val;
        return cmd;
    endfunction

    // Random command, shaped by whether the list is being grown or drained
    function automatic t_in random_command(bit filling, int unsigned held);
        t_in         cmd;
        int unsigned pick;
        cmd.value  = $urandom();
        cmd.index  = 5'($urandom_range(0, 31));
        cmd.action = 2'($urandom_range(0, 3));
        // plain noise
        if ($urandom_range(0, 99) < 10)
            return cmd;
        pick = $urandom_range(0, 99);
        if (filling)
            cmd.action = (pick < 45) ? ACT_APPEND : (pick < 70) ? ACT_INSERT :
                         (pick < 80) ? ACT_DELETE : ACT_READ;
        else
            cmd.action = (pick < 10) ? ACT_APPEND : (pick < 20) ? ACT_INSERT :
                         (pick < 70) ? ACT_DELETE : ACT_READ;
        pick = $urandom_range(0, 99);
        if (pick < 6 && held < 32)
            cmd.index = 5'(held);              // one past the last entry
        else if (pick < 90 && held != 0)
            cmd.index = 5'($urandom_range(0, held - 1));
        return cmd;
    endfunction

    // Drive one command beat; returns at the falling edge after acceptance
    task automatic send_command(input t_in cmd);
        while (!steady && $urandom_range(0, 99) < 17) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= cmd;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        sb.note_command(cmd);
        @(negedge i_clk);
    endtask

    initial begin
        bit filling;
        int n;
        sb          = new();
        steady      = 1'b0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_ready = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty list, extremes, boundaries of the index check
        send_command(command_beat(ACT_READ,   0,  32'h1234_5678));
        send_command(command_beat(ACT_DELETE, 0,  32'h0));
        send_command(command_beat(ACT_INSERT, 0,  32'hDEAD_BEEF)); // index equals count
        send_command(command_beat(ACT_APPEND, 31, 32'h7FFF_FFFF));
        send_command(command_beat(ACT_APPEND, 0,  32'h8000_0000));
        send_command(command_beat(ACT_INSERT, 0,  32'hFFFF_FFFF));
        send_command(command_beat(ACT_INSERT, 3,  32'h0BAD_0BAD)); // index equals count
        send_command(command_beat(ACT_INSERT, 2,  32'h0000_0000));
        send_command(command_beat(ACT_READ,   0,  32'hFFFF_FFFF));
        send_command(command_beat(ACT_READ,   1,  32'h0));
        send_command(command_beat(ACT_READ,   2,  32'h0));
        send_command(command_beat(ACT_READ,   3,  32'h0));
        send_command(command_beat(ACT_READ,   4,  32'h0));
        send_command(command_beat(ACT_READ,   31, 32'h0));
        send_command(command_beat(ACT_DELETE, 3,  32'h0));         // last entry
        send_command(command_beat(ACT_DELETE, 0,  32'h0));
        send_command(command_beat(ACT_DELETE, 5,  32'h0));         // bad index
        send_command(command_beat(ACT_READ,   0,  32'h0));
        send_command(command_beat(ACT_READ,   1,  32'h0));
        send_command(command_beat(ACT_APPEND, 31, 32'h5555_5555));
        send_command(command_beat(ACT_DELETE, 31, 32'hAAAA_AAAA));

        // Random: sweep the count between empty and full, over and over
        filling = 1'b1;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            steady <= (n >= 600 && n < 900);
            if (filling && sb.count == CAPACITY && $urandom_range(0, 3) == 0)
                filling = 1'b0;
            else if (!filling && sb.count == 0 && $urandom_range(0, 1) == 0)
                filling = 1'b1;
            send_command(random_command(filling, sb.count));
        end
        i_in_valid <= 1'b0;

        // Drain, then wait for stray beats
        while (sb.expected_q.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (sb.error_count == 0 && sb.expected_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
